FILE: src/nondominated_front_sorter_defines.svh
// assertion macros for the front sorter
`ifndef NONDOMINATED_FRONT_SORTER_DEFINES_SVH
`define NONDOMINATED_FRONT_SORTER_DEFINES_SVH

// property must hold on every clock outside reset
`define NFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define NFS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: src/nfs_pkg.sv
// shared constants, types and states of the front sorter
`default_nettype none
package nfs_pkg;
	localparam int MAX_POP   = 64;
	localparam int MAX_OBJ   = 8;
	localparam int VALUE_W   = 32;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int OBJ_W     = 3;
	localparam int NOBJ_W    = 4;
	localparam int FIT_AW    = 9;
	localparam int ORD_W     = 12;

	typedef struct packed {
		logic              en;
		logic [FIT_AW-1:0] addr;
		logic [VALUE_W-1:0] data;
	} nfs_fwr_t;

	typedef struct packed {
		logic              go;
		logic [CNT_W-1:0]  pop;
		logic [NOBJ_W-1:0] nobj;
	} nfs_start_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_PAIR, ST_CMP, ST_CWAIT, ST_CRD, ST_CWR,
		ST_SCAN, ST_SCHK, ST_PSEL, ST_PORD, ST_PROW, ST_PSCAN, ST_PDEC,
		ST_ORD, ST_OSHOW, ST_OWAIT
	} nfs_state_t;
endpackage
`default_nettype wire

FILE: src/nondominated_front_sorter.sv
// top level: loads fitness vectors, then ranks the population into fronts
// Input channel in_valid/in_ready carries one objective value per transfer,
// individual-major; last_individual matters only with an individual's final value.
// Config channel cfg_valid/cfg_ready/cfg_data writes num_objectives (reset 2).
// Values may be taken back to back while in_ready is high. After the final
// value of the marked individual, in_ready drops while the sequencer clears
// the counts, compares every ordered pair one objective per cycle (pop * (pop - 1)
// pairs), scans for front zero and then peels the later fronts.
// Results then leave on out_valid/out_ready one at a time, each held until taken,
// ordered by front, last_result on the final one. A stalled receiver holds the
// result and the sequencer. Reset returns to an empty load with no result.
`default_nettype none
module nondominated_front_sorter
	import nfs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [NOBJ_W-1:0]         cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [VALUE_W-1:0] fitness_value,
	input  wire logic                      last_individual,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [IDX_W-1:0]               individual_index,
	output logic [IDX_W-1:0]               front_number,
	output logic                           last_result
);
	`include "nondominated_front_sorter_defines.svh"

	logic [NOBJ_W-1:0] nobj_q, m;
	logic [OBJ_W-1:0]  load_q, pos;
	logic [CNT_W-1:0]  pop_q, pop_nx;
	logic              fin, accept, idle;
	nfs_fwr_t          fwr;
	nfs_start_t        start;

	assign cfg_ready = 1'b1;
	assign in_ready  = idle;
	assign accept    = in_valid && in_ready;

	always_comb begin
		if (nobj_q == '0) m = NOBJ_W'(1);
		else if (nobj_q > NOBJ_W'(MAX_OBJ)) m = NOBJ_W'(MAX_OBJ);
		else m = nobj_q;
		pos    = ({1'b0, load_q} >= m) ? OBJ_W'(m - NOBJ_W'(1)) : load_q;
		fin    = ({1'b0, pos} + NOBJ_W'(1) >= m);
		pop_nx = pop_q + CNT_W'(!pop_q[CNT_W-1]);
	end

	always_comb begin
		fwr.en     = accept && !pop_q[CNT_W-1];
		fwr.addr   = {pop_q[IDX_W-1:0], pos};
		fwr.data   = fitness_value ^ {1'b1, {(VALUE_W-1){1'b0}}};
		start.go   = accept && fin && last_individual;
		start.pop  = pop_nx;
		start.nobj = m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nobj_q <= NOBJ_W'(2);
			load_q <= '0;
			pop_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) nobj_q <= cfg_data;
			if (accept) begin
				if (!fin) begin
					load_q <= pos + OBJ_W'(1);
				end else begin
					load_q <= '0;
					pop_q  <= last_individual ? '0 : pop_nx;
				end
			end
		end
	end

	nfs_core u_core (
		.clk(clk), .arst_n(arst_n), .fwr(fwr), .start(start), .idle(idle),
		.out_valid(out_valid), .out_ready(out_ready),
		.individual_index(individual_index), .front_number(front_number),
		.last_result(last_result)
	);

	`NFS_NEVER(a_no_overlap, in_ready && out_valid, "input taken while reporting")
	`NFS_ASSERT(a_back_to_load, out_valid && out_ready && last_result |=> in_ready, "no return to loading")
	`NFS_NEVER(a_pop_range, pop_q > CNT_W'(MAX_POP), "population count out of range")
	`NFS_ASSERT(a_go_stops_load, start.go |=> !in_ready, "loading continued after final item")
endmodule
`default_nettype wire

FILE: src/nfs_ram.sv
// generic single write port ram with registered read
`default_nettype none
module nfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/nfs_core.sv
// dominance build, front peeling and report sequencer with its memories
`default_nettype none
module nfs_core
	import nfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nfs_fwr_t          fwr,
	input  wire nfs_start_t        start,
	output logic                   idle,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [IDX_W-1:0]       individual_index,
	output logic [IDX_W-1:0]       front_number,
	output logic                   last_result
);
	nfs_state_t state_q, state_nx;

	logic [CNT_W-1:0]   pop_q, i_q, j_q, w_q, tail_q, end_q;
	logic [NOBJ_W-1:0]  nobj_q;
	logic [OBJ_W-1:0]   ob_q;
	logic               ob_vld_s1;
	logic               le_q, same_q;
	logic [MAX_POP-1:0] row_q;
	logic [IDX_W-1:0]   front_q;

	logic [VALUE_W-1:0] fa_rd, fb_rd;
	logic [MAX_POP-1:0] dom_rd, dom_wd;
	logic               dom_we;
	logic [CNT_W-1:0]   cnt_rd, cnt_wd;
	logic               cnt_we;
	logic [ORD_W-1:0]   ord_rd, ord_wd;
	logic               ord_we;
	logic [OBJ_W-1:0]   ob_last;
	logic               dom_bit;

	assign ob_last = OBJ_W'(nobj_q - NOBJ_W'(1));
	assign dom_bit = le_q && !same_q;

	nfs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_POP * MAX_OBJ)) u_fit_a (
		.clk(clk), .we(fwr.en), .waddr(fwr.addr), .wdata(fwr.data),
		.raddr({i_q[IDX_W-1:0], ob_q}), .rdata(fa_rd)
	);
	nfs_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_POP * MAX_OBJ)) u_fit_b (
		.clk(clk), .we(fwr.en), .waddr(fwr.addr), .wdata(fwr.data),
		.raddr({j_q[IDX_W-1:0], ob_q}), .rdata(fb_rd)
	);
	nfs_ram #(.WIDTH(MAX_POP), .DEPTH(MAX_POP)) u_dom (
		.clk(clk), .we(dom_we), .waddr(i_q[IDX_W-1:0]), .wdata(dom_wd),
		.raddr(ord_rd[IDX_W-1:0]), .rdata(dom_rd)
	);
	nfs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POP)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(j_q[IDX_W-1:0]), .wdata(cnt_wd),
		.raddr(j_q[IDX_W-1:0]), .rdata(cnt_rd)
	);
	nfs_ram #(.WIDTH(ORD_W), .DEPTH(MAX_POP)) u_ord (
		.clk(clk), .we(ord_we), .waddr(tail_q[IDX_W-1:0]), .wdata(ord_wd),
		.raddr(w_q[IDX_W-1:0]), .rdata(ord_rd)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (start.go) state_nx = ST_CLR;
			ST_CLR:   if (j_q == pop_q - CNT_W'(1)) state_nx = ST_PAIR;
			ST_PAIR: begin
				if (i_q == pop_q) state_nx = ST_SCAN;
				else if (j_q != pop_q && i_q != j_q) state_nx = ST_CMP;
			end
			ST_CMP:   if (ob_q == ob_last) state_nx = ST_CWAIT;
			ST_CWAIT: state_nx = ST_CRD;
			ST_CRD:   state_nx = dom_bit ? ST_CWR : ST_PAIR;
			ST_CWR:   state_nx = ST_PAIR;
			ST_SCAN:  state_nx = ST_SCHK;
			ST_SCHK:  state_nx = (j_q == pop_q - CNT_W'(1)) ? ST_PSEL : ST_SCAN;
			ST_PSEL: begin
				if (w_q != end_q) state_nx = ST_PORD;
				else if (end_q == tail_q) state_nx = ST_ORD;
			end
			ST_PORD:  state_nx = ST_PROW;
			ST_PROW:  state_nx = ST_PSCAN;
			ST_PSCAN: begin
				if (j_q == pop_q) state_nx = ST_PSEL;
				else if (row_q[j_q[IDX_W-1:0]]) state_nx = ST_PDEC;
			end
			ST_PDEC:  state_nx = ST_PSCAN;
			ST_ORD:   state_nx = ST_OSHOW;
			ST_OSHOW: state_nx = ST_OWAIT;
			ST_OWAIT: begin
				if (out_ready) state_nx = (w_q + CNT_W'(1) == tail_q) ? ST_IDLE : ST_ORD;
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		dom_we = (state_q == ST_PAIR) && (i_q != pop_q) && (j_q == pop_q);
		dom_wd = row_q;
		cnt_we = 1'b0;
		cnt_wd = '0;
		ord_we = 1'b0;
		ord_wd = '0;
		case (state_q)
			ST_CLR: cnt_we = 1'b1;
			ST_CWR: begin
				cnt_we = 1'b1;
				cnt_wd = cnt_rd + CNT_W'(1);
			end
			ST_SCHK: begin
				ord_we = (cnt_rd == '0);
				ord_wd = {IDX_W'(0), j_q[IDX_W-1:0]};
			end
			ST_PDEC: begin
				cnt_we = 1'b1;
				cnt_wd = cnt_rd - CNT_W'(1);
				ord_we = (cnt_rd == CNT_W'(1));
				ord_wd = {front_q + IDX_W'(1), j_q[IDX_W-1:0]};
			end
			default: cnt_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pop_q     <= '0;
			nobj_q    <= NOBJ_W'(1);
			i_q       <= '0;
			j_q       <= '0;
			w_q       <= '0;
			tail_q    <= '0;
			end_q     <= '0;
			ob_q      <= '0;
			ob_vld_s1 <= 1'b0;
			le_q      <= 1'b0;
			same_q    <= 1'b0;
			front_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_nx;
			ob_vld_s1 <= (state_q == ST_CMP);
			if (ob_vld_s1) begin
				le_q   <= le_q && (fa_rd <= fb_rd);
				same_q <= same_q && (fa_rd == fb_rd);
			end
			case (state_q)
				ST_IDLE: begin
					if (start.go) begin
						pop_q  <= start.pop;
						nobj_q <= start.nobj;
						j_q    <= '0;
					end
				end
				ST_CLR: begin
					if (j_q == pop_q - CNT_W'(1)) begin
						i_q <= '0;
						j_q <= '0;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_PAIR: begin
					if (i_q == pop_q) begin
						j_q    <= '0;
						tail_q <= '0;
					end else if (j_q == pop_q) begin
						i_q <= i_q + CNT_W'(1);
						j_q <= '0;
					end else if (i_q == j_q) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						ob_q   <= '0;
						le_q   <= 1'b1;
						same_q <= 1'b1;
					end
				end
				ST_CMP:  ob_q <= ob_q + OBJ_W'(1);
				ST_CRD:  if (!dom_bit) j_q <= j_q + CNT_W'(1);
				ST_CWR:  j_q <= j_q + CNT_W'(1);
				ST_SCHK: begin
					if (cnt_rd == '0) tail_q <= tail_q + CNT_W'(1);
					j_q <= j_q + CNT_W'(1);
					if (j_q == pop_q - CNT_W'(1)) begin
						w_q     <= '0;
						end_q   <= tail_q + CNT_W'(cnt_rd == '0);
						front_q <= '0;
					end
				end
				ST_PSEL: begin
					if (w_q == end_q) begin
						if (end_q == tail_q) begin
							w_q <= '0;
						end else begin
							end_q   <= tail_q;
							front_q <= front_q + IDX_W'(1);
						end
					end
				end
				ST_PROW: j_q <= '0;
				ST_PSCAN: begin
					if (j_q == pop_q) w_q <= w_q + CNT_W'(1);
					else if (!row_q[j_q[IDX_W-1:0]]) j_q <= j_q + CNT_W'(1);
				end
				ST_PDEC: begin
					j_q <= j_q + CNT_W'(1);
					if (cnt_rd == CNT_W'(1)) tail_q <= tail_q + CNT_W'(1);
				end
				ST_OSHOW: out_valid <= 1'b1;
				ST_OWAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						w_q       <= w_q + CNT_W'(1);
					end
				end
				default: out_valid <= out_valid;
			endcase
		end
	end

	// row register and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CLR:   row_q <= '0;
			ST_PAIR:  if (j_q == pop_q) row_q <= '0;
			ST_CRD:   if (dom_bit) row_q[j_q[IDX_W-1:0]] <= 1'b1;
			ST_PROW:  row_q <= dom_rd;
			ST_OSHOW: begin
				individual_index <= ord_rd[IDX_W-1:0];
				front_number     <= ord_rd[ORD_W-1:IDX_W];
				last_result      <= (w_q + CNT_W'(1) == tail_q);
			end
			default:  row_q <= row_q;
		endcase
	end

	assign idle = (state_q == ST_IDLE);
endmodule
`default_nettype wire

FILE: tb/sv/nondominated_front_sorter_checker.sv
// checker for the front sorter: predicts population ranking and compares reported results
`timescale 1ns / 1ps
`default_nettype none
module nondominated_front_sorter_checker
	import nfs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	input  wire logic                      cfg_ready,
	input  wire logic [NOBJ_W-1:0]         cfg_data,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire logic signed [VALUE_W-1:0] fitness_value,
	input  wire logic                      last_individual,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire logic [IDX_W-1:0]          individual_index,
	input  wire logic [IDX_W-1:0]          front_number,
	input  wire logic                      last_result,
	input  wire logic                      done,
	output int                             fail_count,
	output int                             pending
);
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] front;
		logic             last;
	} rank_entry_t;

	logic [VALUE_W-1:0] key_store [MAX_POP][MAX_OBJ];
	logic [NOBJ_W-1:0]  obj_reg;
	int                 load_pos;
	int                 pop_count;
	rank_entry_t        rank_queue [$];
	logic               done_seen;

	assign pending = rank_queue.size();

	task automatic report_error(input string what);
		$display("error at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic int active_obj();
		if (obj_reg == 0) return 1;
		if (obj_reg > MAX_OBJ) return MAX_OBJ;
		return obj_reg;
	endfunction

	task automatic rank_population(input int pop, input int m);
		logic [MAX_POP-1:0] dom_row [MAX_POP];
		int                 remaining [MAX_POP];
		logic [IDX_W-1:0]   front_of [MAX_POP];
		int                 order [$];
		int                 start, stop, front, p;
		logic               le, same;
		rank_entry_t        e;
		for (int i = 0; i < pop; i++) begin
			dom_row[i] = '0;
			remaining[i] = 0;
		end
		for (int i = 0; i < pop; i++) begin
			for (int j = 0; j < pop; j++) begin
				if (i != j) begin
					le = 1'b1;
					same = 1'b1;
					for (int k = 0; k < m; k++) begin
						if (key_store[i][k] > key_store[j][k]) le = 1'b0;
						if (key_store[i][k] != key_store[j][k]) same = 1'b0;
					end
					if (le && !same) begin
						dom_row[i][j] = 1'b1;
						remaining[j]++;
					end
				end
			end
		end
		for (int i = 0; i < pop; i++) begin
			if (remaining[i] == 0) begin
				order = {order, i};
				front_of[i] = '0;
			end
		end
		start = 0;
		front = 0;
		while (start < order.size()) begin
			stop = order.size();
			for (int k = start; k < stop; k++) begin
				p = order[k];
				for (int j = 0; j < pop; j++) begin
					if (dom_row[p][j]) begin
						remaining[j]--;
						if (remaining[j] == 0 && order.size() < MAX_POP) begin
							order = {order, j};
							front_of[j] = IDX_W'(front + 1);
						end
					end
				end
			end
			start = stop;
			front++;
		end
		foreach (order[k]) begin
			e.idx = IDX_W'(order[k]);
			e.front = front_of[order[k]];
			e.last = (k == order.size() - 1);
			rank_queue = {rank_queue, e};
		end
	endtask

	task automatic load_value(input logic [VALUE_W-1:0] v, input logic last);
		int m, pos;
		m = active_obj();
		pos = load_pos;
		if (pos >= m) pos = m - 1;
		if (pop_count < MAX_POP) key_store[pop_count][pos] = v ^ {1'b1, {(VALUE_W-1){1'b0}}};
		if (pos + 1 < m) begin
			load_pos = pos + 1;
		end else begin
			load_pos = 0;
			if (pop_count < MAX_POP) pop_count++;
			if (last) begin
				rank_population(pop_count, m);
				pop_count = 0;
			end
		end
	endtask

	initial begin
		fail_count = 0;
		obj_reg = 4'd2;
		load_pos = 0;
		pop_count = 0;
		done_seen = 1'b0;
	end

	always @(posedge clk) begin
		rank_entry_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) obj_reg = cfg_data;
			if (in_valid && in_ready) load_value(fitness_value, last_individual);
			if (out_valid && out_ready) begin
				if (rank_queue.size() == 0) begin
					report_error($sformatf("unexpected result index %0d", individual_index));
				end else begin
					e = rank_queue.pop_front();
					if (individual_index !== e.idx)
						report_error($sformatf("index %0d, predicted %0d", individual_index, e.idx));
					if (front_number !== e.front)
						report_error($sformatf("front %0d, predicted %0d for index %0d",
							front_number, e.front, e.idx));
					if (last_result !== e.last)
						report_error($sformatf("last mark %0b, predicted %0b for index %0d",
							last_result, e.last, e.idx));
				end
			end
			if (done && !done_seen) begin
				done_seen = 1'b1;
				if (rank_queue.size() != 0)
					report_error($sformatf("%0d results never reported", rank_queue.size()));
			end
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/nondominated_front_sorter_tb.sv
// testbench top for the front sorter: stimulus, idling and verdict
`timescale 1ns / 1ps
`default_nettype none
module nondominated_front_sorter_tb;
	import nfs_pkg::*;

	localparam int IDLE_LIMIT = 400000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [NOBJ_W-1:0]         cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [VALUE_W-1:0] fitness_value;
	logic                      last_individual;
	logic                      out_valid;
	logic                      out_ready;
	logic [IDX_W-1:0]          individual_index;
	logic [IDX_W-1:0]          front_number;
	logic                      last_result;
	logic                      done;
	logic                      idling_on;
	int                        fail_count;
	int                        pending;
	int                        items_sent;
	int                        quiet_cycles;

	nondominated_front_sorter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.fitness_value(fitness_value), .last_individual(last_individual),
		.out_valid(out_valid), .out_ready(out_ready),
		.individual_index(individual_index), .front_number(front_number),
		.last_result(last_result)
	);

	nondominated_front_sorter_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.fitness_value(fitness_value), .last_individual(last_individual),
		.out_valid(out_valid), .out_ready(out_ready),
		.individual_index(individual_index), .front_number(front_number),
		.last_result(last_result), .done(done),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= idling_on ? ($urandom_range(99) >= 6) : 1'b1;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
		if (idling_on && $urandom_range(99) < 6) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		fitness_value <= v;
		last_individual <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_objectives(input logic [NOBJ_W-1:0] d);
		@(negedge clk);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic int clamp_obj(input logic [NOBJ_W-1:0] d);
		if (d == 0) return 1;
		if (d > MAX_OBJ) return MAX_OBJ;
		return d;
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value(input int mode);
		case (mode)
			0: return $urandom();
			1: return VALUE_W'($signed($urandom_range(4)) - 2);
			default: return VALUE_W'($signed($urandom_range(40)) - 20) <<< 16;
		endcase
	endfunction

	task automatic send_population(input int pop, input int m, input int mode);
		for (int i = 0; i < pop; i++)
			for (int k = 0; k < m; k++)
				send_value(pick_value(mode), (i == pop - 1) || ($urandom_range(9) == 0 && k < m - 1));
	endtask

	initial begin
		logic [NOBJ_W-1:0] obj;
		int                pop;
		int                big_done;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		fitness_value = '0;
		last_individual = 1'b0;
		out_ready = 1'b0;
		done = 1'b0;
		idling_on = 1'b0;
		items_sent = 0;
		quiet_cycles = 0;
		big_done = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes, identical vectors, last mark on a non-final objective
		send_value(32'h8000_0000, 1'b1);
		send_value(32'h7fff_ffff, 1'b0);
		send_value(32'h7fff_ffff, 1'b0);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'hffff_ffff, 1'b0);
		send_value(32'hffff_ffff, 1'b1);
		wait_drained();
		// zero objective count acts as one
		write_objectives(4'd0);
		send_value(32'h0005_0000, 1'b0);
		send_value(32'h0003_0000, 1'b0);
		send_value(32'h0003_0000, 1'b1);
		wait_drained();
		// count above the maximum acts as the maximum
		write_objectives(4'd15);
		for (int k = 0; k < 16; k++)
			send_value(k < 8 ? k : 7 - k, k == 15);
		wait_drained();
		// count lowered in the middle of a load
		write_objectives(4'd3);
		send_value(32'd1, 1'b0);
		send_value(32'd2, 1'b0);
		send_value(32'd3, 1'b0);
		send_value(32'd4, 1'b0);
		write_objectives(4'd1);
		send_value(32'd5, 1'b1);
		wait_drained();
		// population overflow
		for (int i = 0; i < MAX_POP + 2; i++)
			send_value(pick_value(i % 3), i == MAX_POP + 1);
		wait_drained();

		obj = 4'd1;
		while (items_sent < 430) begin
			idling_on = !(items_sent >= 180 && items_sent < 290);
			if ($urandom_range(2) == 0) begin
				wait_drained();
				obj = ($urandom_range(3) == 0) ? NOBJ_W'($urandom_range(15))
					: NOBJ_W'($urandom_range(1, 3));
				write_objectives(obj);
			end
			if (big_done == 0 && items_sent > 300) begin
				wait_drained();
				obj = 4'd1;
				write_objectives(obj);
				pop = MAX_POP;
				big_done = 1;
			end else begin
				pop = $urandom_range(1, clamp_obj(obj) > 4 ? 5 : 10);
			end
			send_population(pop, clamp_obj(obj), $urandom_range(2));
			if ($urandom_range(4) == 0) wait_drained();
		end

		wait_drained();
		@(negedge clk);
		done <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/nfs_pkg.sv
src/nfs_ram.sv
src/nfs_core.sv
src/nondominated_front_sorter.sv
tb/sv/nondominated_front_sorter_checker.sv
tb/sv/nondominated_front_sorter_tb.sv
